@@ sv/cheapest_insertion_tour_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef CHEAPEST_INSERTION_TOUR_CORE_ASSERT_SVH
`define CHEAPEST_INSERTION_TOUR_CORE_ASSERT_SVH
// Implication checked every clock, quiet while reset is held.
`define CIT_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, quiet while reset is held.
`define CIT_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ sv/cit_pkg.sv @@
// ----------------------------------------------------------------------------
// cit_pkg
// Shared types and constants of the cheapest insertion tour core.
// ----------------------------------------------------------------------------
package cit_pkg;
  localparam int CoordW = 16;
  localparam int DistW  = 18;
  localparam int LenW   = 24;
  localparam int SqW    = 34;
  localparam int DeltaW = 21;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [SqW-1:0] sq_t;
  typedef logic signed [DeltaW-1:0] delta_t;
endpackage

@@ sv/cheapest_insertion_tour_core.sv @@
// ----------------------------------------------------------------------------
// cheapest_insertion_tour_core
// Cheapest insertion tour heuristic over NUM_CITIES cities in Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_x_coord/in_y_coord and hold start until busy is low; one
//   request per city, in index order.
//   After the last city the core goes busy: it forms every pairwise distance
//   with one shared squarer and a bit-serial square root, seeds the tour with
//   the nearest neighbor of city 0, then runs the insertion search with one
//   distance read at a time, then sums the tour.
//   Results: N results, one per cycle, each marked by out_valid for exactly
//   one cycle; out_final_city marks the last. The receiver cannot stall.
//   Reset (rst_n low, synchronous) empties the city set and returns to idle.
//   Throughput: one tour per N loads; the next load is taken after the last
//   result.
// ----------------------------------------------------------------------------
module cheapest_insertion_tour_core #(
  parameter int NUM_CITIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cit_pkg::coord_t      in_x_coord,
  input  cit_pkg::coord_t      in_y_coord,
  output logic                 out_valid,
  output logic [5:0]           out_tour_position,
  output logic [5:0]           out_city_number,
  output cit_pkg::len_t        out_tour_length,
  output logic                 out_final_city
);
  localparam int CW = (NUM_CITIES > 2) ? $clog2(NUM_CITIES) : 1;
  localparam int NW = $clog2(NUM_CITIES + 1);
  localparam int DAW = 2 * CW;
  localparam int SQW = cit_pkg::SqW;
  localparam int DW = cit_pkg::DistW;
  localparam int DTW = cit_pkg::DeltaW;
  localparam logic [NW-1:0] NLAST = NW'(NUM_CITIES - 1);
  localparam logic [NW-1:0] NCNT = NW'(NUM_CITIES);
  localparam logic [CW-1:0] CLAST = CW'(NUM_CITIES - 1);
  localparam logic [5:0] OLAST = 6'(NUM_CITIES - 1);

  // state codes
  localparam logic [3:0] S_IDLE = 4'd0, S_DRD = 4'd1, S_DSQ = 4'd2,
                         S_DRT = 4'd3, S_NRD = 4'd4, S_NCK = 4'd5,
                         S_IRD = 4'd6, S_IACC = 4'd7, S_SHF = 4'd8,
                         S_LRD = 4'd9, S_LACC = 4'd10, S_EMIT = 4'd11,
                         S_DRD2 = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [NW-1:0] load_cnt_r;
  logic [CW-1:0] i_r, j_r, k_r;
  logic [NW-1:0] p_r, size_r;
  logic [1:0] ph_r;
  logic [4:0] bit_r;
  logic [NUM_CITIES-1:0] vis_r;
  logic [CW-1:0] tour_r [NUM_CITIES];
  logic found_r;
  cit_pkg::delta_t best_r, acc_r;
  logic [CW-1:0] bcity_r;
  logic [NW-1:0] bpos_r;
  logic [25:0] total_r;
  cit_pkg::coord_t xi_r, yi_r;
  cit_pkg::sq_t sq_r, rem_r, root_r;
  logic [5:0] opos_r;

  // coordinate memory
  logic c_we;
  logic [CW-1:0] c_raddr;
  logic [31:0] c_rdata;
  cit_ram #(.WIDTH(32), .DEPTH(NUM_CITIES)) u_coord (
    .clk(clk), .we(c_we), .waddr(load_cnt_r[CW-1:0]),
    .wdata({in_x_coord, in_y_coord}), .raddr(c_raddr), .rdata(c_rdata));

  // one root step: trial subtract on the remainder
  logic [SQW-1:0] trial;
  logic [SQW-1:0] rbit;
  logic [SQW-1:0] root_step;
  logic root_take;
  always_comb begin
    rbit = SQW'(1) << {bit_r, 1'b0};
    trial = root_r + rbit;
    root_take = (rem_r >= trial);
    root_step = root_take ? ((root_r >> 1) + rbit) : (root_r >> 1);
  end

  // distance memory, written with the last root step
  logic d_we;
  logic [DAW-1:0] d_raddr;
  cit_pkg::dist_t d_rdata;
  cit_ram #(.WIDTH(DW), .DEPTH(1 << DAW)) u_dist (
    .clk(clk), .we(d_we), .waddr({i_r, j_r}), .wdata(root_step[DW-1:0]),
    .raddr(d_raddr), .rdata(d_rdata));

  assign busy = (state_r != S_IDLE);
  assign c_we = start && !busy;
  assign d_we = (state_r == S_DRT) && (bit_r == 5'd0);

  // tour neighbors of position p
  logic [CW-1:0] ta, tb;
  always_comb begin
    ta = tour_r[p_r[CW-1:0]];
    tb = (p_r == size_r - NW'(1)) ? tour_r[0] : tour_r[p_r[CW-1:0] + CW'(1)];
  end

  // memory read addresses
  always_comb begin
    c_raddr = (state_r == S_DRD) ? i_r : j_r;
    d_raddr = '0;
    case (state_r)
      S_NRD, S_NCK: d_raddr = {CW'(0), k_r};
      S_IRD: begin
        case (ph_r)
          2'd0: d_raddr = {ta, k_r};
          2'd1: d_raddr = {k_r, tb};
          default: d_raddr = {ta, tb};
        endcase
      end
      S_LRD: d_raddr = {ta, tb};
      default: d_raddr = '0;
    endcase
  end

  // one shared squarer on a signed 17-bit difference
  logic signed [16:0] diff;
  logic [SQW-1:0] sqv;
  always_comb begin
    diff = (ph_r == 2'd0) ? (17'(xi_r) - 17'($signed(c_rdata[31:16])))
                          : (17'(yi_r) - 17'($signed(c_rdata[15:0])));
    sqv = SQW'(diff * diff);
  end

  // signed distance word and candidate compares
  cit_pkg::delta_t dsx, cand;
  logic better_nn, better_ins;
  logic [CW-1:0] nn_city;
  always_comb begin
    dsx = DTW'(d_rdata);
    cand = acc_r - dsx;
    better_nn = !found_r || (dsx < best_r);
    better_ins = !found_r || (cand < best_r);
    nn_city = better_nn ? k_r : bcity_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (c_we && load_cnt_r == NLAST) state_nxt = S_DRD;
      S_DRD: state_nxt = S_DRD2;
      S_DRD2: state_nxt = S_DSQ;
      S_DSQ: if (ph_r == 2'd1) state_nxt = S_DRT;
      S_DRT: begin
        if (bit_r == 5'd0) begin
          if (j_r != CLAST) state_nxt = S_DRD2;
          else if (i_r != CLAST) state_nxt = S_DRD;
          else state_nxt = S_NRD;
        end
      end
      S_NRD: state_nxt = S_NCK;
      S_NCK: state_nxt = (k_r == CLAST) ? S_IRD : S_NRD;
      S_IRD: begin
        if (size_r == NCNT) state_nxt = S_LRD;
        else if (!vis_r[k_r]) state_nxt = S_IACC;
        else if (k_r == CLAST) state_nxt = S_SHF;
      end
      S_IACC: begin
        if (ph_r == 2'd2 && p_r == size_r - NW'(1) && k_r == CLAST) state_nxt = S_SHF;
        else state_nxt = S_IRD;
      end
      S_SHF: if (!(p_r > bpos_r + NW'(1))) state_nxt = S_IRD;
      S_LRD: state_nxt = S_LACC;
      S_LACC: state_nxt = (p_r == NLAST) ? S_EMIT : S_LRD;
      S_EMIT: if (opos_r == OLAST) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      load_cnt_r <= '0;
      vis_r <= '0;
      size_r <= '0;
      opos_r <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (c_we) begin
            load_cnt_r <= load_cnt_r + NW'(1);
            i_r <= '0;
            j_r <= '0;
          end
        end
        // latch coordinates of row city
        S_DRD2: begin
          if (j_r == '0) begin
            xi_r <= $signed(c_rdata[31:16]);
            yi_r <= $signed(c_rdata[15:0]);
          end
          ph_r <= 2'd0;
        end
        S_DSQ: begin
          if (ph_r == 2'd0) begin
            sq_r <= sqv;
            ph_r <= 2'd1;
          end else begin
            rem_r <= sq_r + sqv;
            root_r <= '0;
            bit_r <= 5'd16;
          end
        end
        S_DRT: begin
          // root bits from 2^16 down to 1
          if (root_take) rem_r <= rem_r - trial;
          root_r <= root_step;
          if (bit_r != 5'd0) bit_r <= bit_r - 5'd1;
          else if (j_r != CLAST) j_r <= j_r + CW'(1);
          else begin
            j_r <= '0;
            i_r <= i_r + CW'(1);
            k_r <= CW'(1);
            found_r <= 1'b0;
          end
        end
        // nearest neighbor of city 0
        S_NCK: begin
          if (k_r == CLAST) begin
            tour_r[0] <= '0;
            tour_r[1] <= nn_city;
            vis_r <= NUM_CITIES'(1) | (NUM_CITIES'(1) << nn_city);
            size_r <= NW'(2);
            k_r <= '0;
            p_r <= '0;
            ph_r <= 2'd0;
            found_r <= 1'b0;
          end else begin
            if (better_nn) begin
              best_r <= dsx;
              bcity_r <= k_r;
              found_r <= 1'b1;
            end
            k_r <= k_r + CW'(1);
          end
        end
        // skip visited cities and finish when cycle is full
        S_IRD: begin
          if (size_r == NCNT) begin
            p_r <= '0;
            total_r <= '0;
          end else if (vis_r[k_r]) begin
            if (k_r == CLAST) p_r <= size_r;
            else k_r <= k_r + CW'(1);
          end
        end
        S_IACC: begin
          if (ph_r == 2'd0) begin
            acc_r <= dsx;
            ph_r <= 2'd1;
          end else if (ph_r == 2'd1) begin
            acc_r <= acc_r + dsx;
            ph_r <= 2'd2;
          end else begin
            ph_r <= 2'd0;
            if (better_ins) begin
              best_r <= cand;
              bcity_r <= k_r;
              bpos_r <= p_r;
              found_r <= 1'b1;
            end
            if (p_r == size_r - NW'(1)) begin
              if (k_r == CLAST) p_r <= size_r;
              else begin
                p_r <= '0;
                k_r <= k_r + CW'(1);
              end
            end else p_r <= p_r + NW'(1);
          end
        end
        // shift tour one slot per cycle, then insert
        S_SHF: begin
          if (p_r > bpos_r + NW'(1)) begin
            tour_r[p_r[CW-1:0]] <= tour_r[p_r[CW-1:0] - CW'(1)];
            p_r <= p_r - NW'(1);
          end else begin
            tour_r[p_r[CW-1:0]] <= bcity_r;
            vis_r[bcity_r] <= 1'b1;
            size_r <= size_r + NW'(1);
            k_r <= '0;
            p_r <= '0;
            found_r <= 1'b0;
            ph_r <= 2'd0;
          end
        end
        S_LACC: begin
          total_r <= total_r + 26'(d_rdata);
          p_r <= p_r + NW'(1);
          opos_r <= '0;
        end
        S_EMIT: begin
          opos_r <= opos_r + 6'd1;
          if (opos_r == OLAST) begin
            load_cnt_r <= '0;
            vis_r <= '0;
            size_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result ports
  assign out_valid = (state_r == S_EMIT);
  assign out_tour_position = opos_r;
  assign out_city_number = 6'(tour_r[opos_r[CW-1:0]]);
  assign out_tour_length = (total_r > 26'hFFFFFF) ? 24'hFFFFFF : total_r[23:0];
  assign out_final_city = out_valid && (opos_r == OLAST);
endmodule

@@ sv/cit_ram.sv @@
// ----------------------------------------------------------------------------
// cit_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/cit_checker.sv @@
// ----------------------------------------------------------------------------
// cit_checker
// Port-level checks on the tour core, bound to the top level.
// ----------------------------------------------------------------------------
`include "cheapest_insertion_tour_core_assert.svh"
module cit_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [5:0] out_tour_position,
  input logic       out_final_city
);
  // results appear only while busy
  `CIT_ASSERT_IMP(a_res_busy, clk, rst_n, out_valid, busy)
  // final marker only on a result
  `CIT_ASSERT_IMP(a_final_valid, clk, rst_n, out_final_city, out_valid)
  // positions count up within a burst
  `CIT_ASSERT_NXT(a_pos_step, clk, rst_n, out_valid && !out_final_city,
    out_valid && out_tour_position == $past(out_tour_position) + 6'd1)
  // the core is idle after the last result
  `CIT_ASSERT_NXT(a_idle_after, clk, rst_n, out_final_city, !busy)
  // an accepted request never yields a result on the next cycle
  `CIT_ASSERT_NXT(a_load_quiet, clk, rst_n, start && !busy, !out_valid)
endmodule

bind cheapest_insertion_tour_core cit_checker u_cit_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_tour_position(out_tour_position),
  .out_final_city(out_final_city));

@@ tb/sv/cheapest_insertion_tour_core_tb.sv @@
// ----------------------------------------------------------------------------
// cheapest_insertion_tour_core_tb
// Loads city sets into the tour core and checks every emitted tour entry
// against a cycle-free model of distances, insertion order and tour length.
// ----------------------------------------------------------------------------
module cheapest_insertion_tour_core_tb;

  localparam int NCity      = 16;
  localparam int MaxCycles  = 2000000;
  localparam int NumRandSet = 7;

  typedef struct {
    logic [5:0]    pos;
    logic [5:0]    city;
    cit_pkg::len_t length;
    logic          last;
  } tour_entry_t;

  typedef struct {
    cit_pkg::coord_t x;
    cit_pkg::coord_t y;
    int     length;  // typed closed length on the last city of a set, -1 if none
  } city_row_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  cit_pkg::coord_t in_x_coord;
  cit_pkg::coord_t in_y_coord;
  logic   out_valid;
  logic [5:0] out_tour_position;
  logic [5:0] out_city_number;
  cit_pkg::len_t out_tour_length;
  logic   out_final_city;

  cheapest_insertion_tour_core #(.NUM_CITIES(NCity)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_tour_position(out_tour_position),
    .out_city_number(out_city_number), .out_tour_length(out_tour_length),
    .out_final_city(out_final_city)
  );

  // Model state
  cit_pkg::coord_t city_x [NCity];
  cit_pkg::coord_t city_y [NCity];
  cit_pkg::dist_t  pair_dist [NCity][NCity];
  int          tour_seq [NCity];
  bit          in_tour [NCity];
  int          cities_loaded;
  tour_entry_t tour_q[$];
  int          mismatches;
  int          cycle_cnt;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Distances, cheapest insertion, tour length, then queue the tour entries.
  task automatic plan_tour(input int typed_len);
    longint dx, dy, delta, best_delta;
    longint unsigned total;
    int nearest, best_city, best_pos, csize, a, b;
    bit found;
    tour_entry_t e;
    for (int i = 0; i < NCity; i++)
      for (int j = 0; j < NCity; j++) begin
        dx = longint'(city_x[i]) - longint'(city_x[j]);
        dy = longint'(city_y[i]) - longint'(city_y[j]);
        pair_dist[i][j] = cit_pkg::dist_t'(isqrt($unsigned(dx * dx + dy * dy)));
      end
    foreach (in_tour[i]) in_tour[i] = 1'b0;
    // seed with city 0 and its nearest neighbor, lowest index on ties
    nearest = 1;
    for (int i = 2; i < NCity; i++)
      if (pair_dist[0][i] < pair_dist[0][nearest]) nearest = i;
    tour_seq[0] = 0;
    tour_seq[1] = nearest;
    in_tour[0] = 1'b1;
    in_tour[nearest] = 1'b1;
    csize = 2;
    while (csize < NCity) begin
      found = 1'b0;
      best_delta = 0;
      best_city = 0;
      best_pos = 0;
      for (int k = 0; k < NCity; k++) begin
        if (in_tour[k]) continue;
        for (int p = 0; p < csize; p++) begin
          a = tour_seq[p];
          b = (p == csize - 1) ? tour_seq[0] : tour_seq[p + 1];
          // signed: flooring can make the added length negative
          delta = longint'(pair_dist[a][k]) + longint'(pair_dist[k][b])
                  - longint'(pair_dist[a][b]);
          if (!found || delta < best_delta) begin
            found = 1'b1;
            best_delta = delta;
            best_city = k;
            best_pos = p;
          end
        end
      end
      for (int m = csize; m > best_pos + 1; m--) tour_seq[m] = tour_seq[m - 1];
      tour_seq[best_pos + 1] = best_city;
      in_tour[best_city] = 1'b1;
      csize++;
    end
    total = 0;
    for (int i = 0; i < NCity; i++)
      total += pair_dist[tour_seq[i]][tour_seq[(i + 1) % NCity]];
    if (total > 64'hFF_FFFF) total = 64'hFF_FFFF;
    for (int i = 0; i < NCity; i++) begin
      e.pos    = 6'(i);
      e.city   = 6'(tour_seq[i]);
      e.length = (typed_len >= 0) ? cit_pkg::len_t'(typed_len) : cit_pkg::len_t'(total);
      e.last   = (i == NCity - 1);
      tour_q.push_back(e);
    end
  endtask

  task automatic load_city(input city_row_t r);
    city_x[cities_loaded] = r.x;
    city_y[cities_loaded] = r.y;
    cities_loaded++;
    if (cities_loaded == NCity) begin
      plan_tour(r.length);
      cities_loaded = 0;
    end
  endtask

  // Issue one request after a random gap; start stays high across back-to-back requests.
  task automatic send_city(input city_row_t r);
    int gap;
    gap = $urandom_range(18);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_x_coord <= r.x;
    in_y_coord <= r.y;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    load_city(r);
  endtask

  function automatic cit_pkg::coord_t rand_coord(input int mode);
    case (mode)
      0:       return cit_pkg::coord_t'($urandom);
      1:       return cit_pkg::coord_t'($urandom_range(64) - 32);   // clustered: ties, negative deltas
      default: return cit_pkg::coord_t'($urandom_range(4096) - 2048);
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    tour_entry_t e;
    if (rst_n && out_valid) begin
      if (tour_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tour entry pos=%0d city=%0d", out_tour_position,
                   out_city_number);
      end else begin
        e = tour_q.pop_front();
        if (out_tour_position !== e.pos || out_city_number !== e.city ||
            out_tour_length !== e.length || out_final_city !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp pos=%0d city=%0d len=%0d last=%0d got %0d %0d %0d %0d",
                     e.pos, e.city, e.length, e.last, out_tour_position,
                     out_city_number, out_tour_length, out_final_city);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    city_row_t dir_rows [NCity];
    city_row_t r;
    int mode;
    mismatches    = 0;
    cycle_cnt     = 0;
    cities_loaded = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    // four cities on each corner of the full coordinate square: convex tour
    for (int i = 0; i < NCity; i++) begin
      dir_rows[i].x = (i % 4 == 1 || i % 4 == 2) ? 16'sh7FFF : 16'sh8000;
      dir_rows[i].y = (i % 4 >= 2) ? 16'sh7FFF : 16'sh8000;
      dir_rows[i].length = -1;
    end
    dir_rows[NCity - 1].length = 4 * 65535;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_city(dir_rows[i]);
    // hold off until the whole directed tour is out
    start <= 1'b0;
    while (tour_q.size() != 0) @(posedge clk);

    for (int s = 0; s < NumRandSet; s++) begin
      mode = s % 3;
      for (int i = 0; i < NCity; i++) begin
        r.x = rand_coord(mode);
        r.y = rand_coord(mode);
        r.length = -1;
        send_city(r);
      end
    end
    start <= 1'b0;

    while (tour_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ cheapest_insertion_tour_core.f @@
+incdir+sv
sv/cit_pkg.sv
sv/cit_ram.sv
sv/cheapest_insertion_tour_core.sv
sv/cit_checker.sv
tb/sv/cheapest_insertion_tour_core_tb.sv
